### design/sbd_pkg.sv
// Shared types, constants and character tables of the strict base64 stream decoder.
package sbd_pkg;

  localparam int unsigned BYTES_W    = 26;
  localparam int unsigned CHARS_W    = 28;
  localparam int unsigned SLOTS      = 5;
  localparam int unsigned HELD_DEPTH = 3;

  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_NO_MARKER = 3'd1;
  localparam logic [2:0] STATUS_SIZE      = 3'd2;
  localparam logic [2:0] STATUS_BAD_CHAR  = 3'd3;
  localparam logic [2:0] STATUS_BAD_PAD   = 3'd4;
  localparam logic [2:0] STATUS_EMPTY     = 3'd5;

  localparam logic [BYTES_W-1:0] MAX_BYTES_RESET = 26'd10485760;
  localparam logic [CHARS_W-1:0] CHARS_MAX       = {CHARS_W{1'b1}};

  localparam logic [7:0] CHAR_PAD  = 8'h3D;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } item_t;

  typedef struct packed {
    logic       is_status;
    logic [7:0] data_byte;
    logic [2:0] status_code;
  } result_t;

  typedef struct packed {
    logic [11:0]        acc;
    logic [2:0]         bit_count;
    logic               pad_found;
    logic [1:0]         padding_total;
    logic [1:0]         symbols;
    logic [BYTES_W-1:0] bytes_out;
    logic [2:0]         first_error;
  } dec_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } symbol_t;

  function automatic symbol_t symbol_lookup(input logic [7:0] c);
    symbol_t s;
    s.valid = 1'b1;
    s.value = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      s.value = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s.value = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s.value = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      s.value = 6'd62;
    end else if (c == 8'h2F) begin
      s.value = 6'd63;
    end else begin
      s.valid = 1'b0;
    end
    return s;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // Characters of the "data:" prefix.
  function automatic logic [7:0] head_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0: c = 8'h64;
      3'd1: c = 8'h61;
      3'd2: c = 8'h74;
      3'd3: c = 8'h61;
      3'd4: c = 8'h3A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Characters of the ";base64," marker.
  function automatic logic [7:0] marker_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0: c = 8'h3B;
      3'd1: c = 8'h62;
      3'd2: c = 8'h61;
      3'd3: c = 8'h73;
      3'd4: c = 8'h65;
      3'd5: c = 8'h36;
      3'd6: c = 8'h34;
      3'd7: c = 8'h2C;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

### design/sbd_decode.sv
// Per-character base64 decode step: symbol lookup, bit accumulation and error tracking.
module sbd_decode (
  input  sbd_pkg::dec_t                cur,
  input  logic [7:0]                   character,
  input  logic [sbd_pkg::BYTES_W-1:0]  max_bytes,
  output sbd_pkg::dec_t                nxt,
  output logic                         byte_valid,
  output logic [7:0]                   data_byte
);

  sbd_pkg::symbol_t sym;
  logic [11:0]      acc_shift;
  logic [11:0]      shifted;
  logic [3:0]       sum;
  logic [2:0]       remain;

  assign sym       = sbd_pkg::symbol_lookup(character);
  assign acc_shift = {cur.acc[5:0], sym.value};
  assign sum       = {1'b0, cur.bit_count} + 4'd6;
  assign remain    = (sum >= 4'd8) ? 3'(sum - 4'd8) : sum[2:0];
  assign shifted   = acc_shift >> remain;

  always_comb begin
    nxt        = cur;
    byte_valid = 1'b0;
    data_byte  = shifted[7:0];
    if (cur.first_error == sbd_pkg::STATUS_OK && !sbd_pkg::is_blank(character)) begin
      if (character == sbd_pkg::CHAR_PAD) begin
        nxt.pad_found = 1'b1;
        nxt.symbols   = cur.symbols + 2'd1;
        if (cur.padding_total >= 2'd2) begin
          nxt.first_error = sbd_pkg::STATUS_BAD_PAD;
        end else begin
          nxt.padding_total = cur.padding_total + 2'd1;
        end
      end else if (cur.pad_found || !sym.valid) begin
        nxt.first_error = sbd_pkg::STATUS_BAD_CHAR;
      end else begin
        nxt.symbols   = cur.symbols + 2'd1;
        nxt.acc       = acc_shift;
        nxt.bit_count = remain;
        if (sum >= 4'd8) begin
          if (cur.bytes_out >= max_bytes) begin
            nxt.first_error = sbd_pkg::STATUS_SIZE;
          end else begin
            byte_valid    = 1'b1;
            nxt.bytes_out = cur.bytes_out + 26'd1;
          end
        end
      end
    end
  end

endmodule

### design/strict_base64_stream_decoder.sv
// Top level of the strict base64 stream decoder with data URL prefix handling.
//
// The char channel carries one character and a last flag per transaction;
// a frame ends with the transaction whose last flag is set. The result
// channel returns decoded bytes as soon as they complete, then one status
// transaction that closes the frame. The cfg channel writes the output size
// limit; it is always ready, and the user must ensure it is written only
// while the block is idle, which the block does not enforce. An accepted
// character lands in an input register and is decoded from there into a
// result queue of up to five entries. While the receiver does not stall,
// the block takes one character per cycle as long as each yields at most
// one result; a character that releases held prefix bytes or ends a frame
// yields up to five results, and the queue drains them one per cycle,
// holding the next character in the input register. Reset empties both
// registers, returns all frame state to its start and sets the limit to
// 10485760 bytes. When the receiver stalls, the queue holds its head, the
// input register takes one more character, and then char stall rises.
module strict_base64_stream_decoder (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         char_valid,
  output logic                         char_stall,
  input  sbd_pkg::item_t               char_data,
  output logic                         result_valid,
  input  logic                         result_stall,
  output sbd_pkg::result_t             result_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [sbd_pkg::BYTES_W-1:0]  cfg_data
);

  localparam logic [1:0] PH_PREFIX = 2'd0;
  localparam logic [1:0] PH_MARKER = 2'd1;
  localparam logic [1:0] PH_DECODE = 2'd2;
  localparam logic [2:0] PREFIX_LAST = 3'd4;
  localparam logic [2:0] MARKER_LAST = 3'd7;

  logic [sbd_pkg::BYTES_W-1:0] max_bytes;

  sbd_pkg::item_t   item;
  logic             item_valid;

  sbd_pkg::result_t slots [sbd_pkg::SLOTS];
  sbd_pkg::result_t slots_next [sbd_pkg::SLOTS];
  logic [2:0]       cnt;
  logic [2:0]       cnt_next;

  logic [1:0]                  phase, phase_next;
  logic [2:0]                  prefix_pos, prefix_pos_next;
  logic [2:0]                  marker_pos, marker_pos_next;
  logic [sbd_pkg::CHARS_W-1:0] chars, chars_next, chars_inc;
  sbd_pkg::dec_t               dec, dec_next, dec_step;
  logic [7:0]                  held [sbd_pkg::HELD_DEPTH];
  logic [7:0]                  held_next [sbd_pkg::HELD_DEPTH];
  logic [1:0]                  ht, ht_next;

  logic                        step_valid;
  logic [7:0]                  step_byte;
  logic [1:0]                  flush_cnt;
  logic                        emit;
  logic [2:0]                  status_pos;
  logic [2:0]                  status;
  logic [sbd_pkg::CHARS_W-1:0] chars_off;
  logic [sbd_pkg::CHARS_W-1:0] chars_k3;
  logic                        over;
  logic                        tail_bad;

  logic out_take;
  logic load;

  assign cfg_ready    = 1'b1;
  assign result_valid = (cnt != 3'd0);
  assign result_data  = slots[0];
  assign out_take     = result_valid && !result_stall;
  assign load         = item_valid && ((cnt == 3'd0) || (cnt == 3'd1 && out_take));
  assign char_stall   = item_valid && !load;

  sbd_decode u_decode (
    .cur        (dec),
    .character  (item.character),
    .max_bytes  (max_bytes),
    .nxt        (dec_step),
    .byte_valid (step_valid),
    .data_byte  (step_byte)
  );

  assign chars_inc = (chars == sbd_pkg::CHARS_MAX) ? chars : chars + 28'd1;

  always_comb begin
    phase_next      = phase;
    prefix_pos_next = prefix_pos;
    marker_pos_next = marker_pos;
    chars_next      = chars;
    dec_next        = dec;
    held_next       = held;
    ht_next         = ht;
    flush_cnt       = 2'd0;
    emit            = 1'b0;

    case (phase)
      PH_PREFIX: begin
        chars_next = chars_inc;
        if (item.character == sbd_pkg::head_char(prefix_pos)) begin
          if (prefix_pos == PREFIX_LAST) begin
            dec_next        = '0;
            phase_next      = PH_MARKER;
            marker_pos_next = 3'd0;
            ht_next         = 2'd0;
            chars_next      = '0;
          end else begin
            prefix_pos_next = prefix_pos + 3'd1;
            dec_next        = dec_step;
            if (step_valid && ht != 2'd3) begin
              held_next[ht] = step_byte;
              ht_next       = ht + 2'd1;
            end
          end
        end else begin
          flush_cnt  = ht;
          ht_next    = 2'd0;
          phase_next = PH_DECODE;
          dec_next   = dec_step;
          emit       = step_valid;
        end
      end
      PH_MARKER: begin
        if (item.character == sbd_pkg::marker_char(marker_pos)) begin
          marker_pos_next = marker_pos + 3'd1;
          if (marker_pos == MARKER_LAST) begin
            phase_next = PH_DECODE;
            chars_next = '0;
          end
        end else begin
          marker_pos_next = (item.character == sbd_pkg::CHAR_SEMI) ? 3'd1 : 3'd0;
        end
      end
      PH_DECODE: begin
        chars_next = chars_inc;
        dec_next   = dec_step;
        emit       = step_valid;
      end
      default: begin
        phase_next = PH_PREFIX;
      end
    endcase

    if (item.last && phase_next == PH_PREFIX) begin
      flush_cnt = ht_next;
    end
  end

  // Length limit: chars > 4*ceil(max/3) + 16 is the same as
  // chars >= 17 with 3*floor((chars - 17)/4) >= max.
  assign chars_off = chars_next - 28'd17;
  assign chars_k3  = {2'b00, chars_off[sbd_pkg::CHARS_W-1:2]}
                   + {1'b0, chars_off[sbd_pkg::CHARS_W-1:2], 1'b0};
  assign over      = (chars_next >= 28'd17) && (chars_k3 >= {2'b00, max_bytes});

  assign tail_bad = (dec_next.symbols != 2'd0) || (dec_next.bit_count == 3'd6)
                 || (dec_next.bit_count == 3'd2 && dec_next.acc[1:0] != 2'd0)
                 || (dec_next.bit_count == 3'd4 && dec_next.acc[3:0] != 4'd0)
                 || (dec_next.padding_total == 2'd1 && dec_next.bit_count != 3'd2)
                 || (dec_next.padding_total == 2'd2 && dec_next.bit_count != 3'd4);

  always_comb begin
    if (phase_next == PH_MARKER) begin
      status = sbd_pkg::STATUS_NO_MARKER;
    end else if (over) begin
      status = sbd_pkg::STATUS_SIZE;
    end else if (dec_next.first_error != sbd_pkg::STATUS_OK) begin
      status = dec_next.first_error;
    end else if (dec_next.bytes_out == '0) begin
      status = sbd_pkg::STATUS_EMPTY;
    end else if (tail_bad) begin
      status = sbd_pkg::STATUS_BAD_PAD;
    end else begin
      status = sbd_pkg::STATUS_OK;
    end
  end

  assign status_pos = {1'b0, flush_cnt} + {2'b00, emit};
  assign cnt_next   = status_pos + {2'b00, item.last};

  always_comb begin
    for (int i = 0; i < sbd_pkg::SLOTS; i++) begin
      slots_next[i] = '0;
    end
    for (int i = 0; i < sbd_pkg::HELD_DEPTH; i++) begin
      slots_next[i] = '{is_status: 1'b0, data_byte: held_next[i],
                        status_code: sbd_pkg::STATUS_OK};
    end
    if (emit) begin
      slots_next[{1'b0, flush_cnt}] = '{is_status: 1'b0, data_byte: step_byte,
                                        status_code: sbd_pkg::STATUS_OK};
    end
    if (item.last) begin
      slots_next[status_pos] = '{is_status: 1'b1, data_byte: 8'h00, status_code: status};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes  <= sbd_pkg::MAX_BYTES_RESET;
      item_valid <= 1'b0;
      cnt        <= 3'd0;
      phase      <= PH_PREFIX;
      prefix_pos <= 3'd0;
      marker_pos <= 3'd0;
      chars      <= '0;
      dec        <= '0;
      ht         <= 2'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_bytes <= cfg_data;
      end
      if (!char_stall) begin
        item_valid <= char_valid;
      end
      if (load) begin
        cnt <= cnt_next;
        if (item.last) begin
          phase      <= PH_PREFIX;
          prefix_pos <= 3'd0;
          marker_pos <= 3'd0;
          chars      <= '0;
          dec        <= '0;
          ht         <= 2'd0;
        end else begin
          phase      <= phase_next;
          prefix_pos <= prefix_pos_next;
          marker_pos <= marker_pos_next;
          chars      <= chars_next;
          dec        <= dec_next;
          ht         <= ht_next;
        end
      end else if (out_take) begin
        cnt <= cnt - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!char_stall && char_valid) begin
      item <= char_data;
    end
    if (load) begin
      held  <= held_next;
      slots <= slots_next;
    end else if (out_take) begin
      for (int i = 0; i < sbd_pkg::SLOTS - 1; i++) begin
        slots[i] <= slots[i + 1];
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_data.is_status |-> cnt == 3'd1)
    else $error("A status transaction is not the last queued result.");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_data.is_status |-> result_data.data_byte == 8'h00)
    else $error("A status transaction carries a nonzero data byte.");

  assert property (@(posedge clk) disable iff (rst)
    phase == PH_MARKER |-> ht == 2'd0)
    else $error("Held bytes remain while searching for the marker.");

  assert property (@(posedge clk) disable iff (rst)
    load && item.last |=> phase == PH_PREFIX && chars == '0 && ht == 2'd0)
    else $error("Frame state was not cleared after the last character.");

endmodule
